### rtl/date_string_check_monotonic_assert.svh
// Assertion macros for the date string checker.
`ifndef DATE_STRING_CHECK_MONOTONIC_ASSERT_SVH
`define DATE_STRING_CHECK_MONOTONIC_ASSERT_SVH

// Condition that must hold in the same cycle as its trigger.
`define DSCM_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Condition that must hold in the cycle after its trigger.
`define DSCM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### rtl/dscm_pkg.sv
// Constants, types and helper functions for the date string checker.
package dscm_pkg;

  localparam int STRING_LENGTH = 10;
  localparam int CNT_W         = 4;
  localparam int ACC_W         = 14;

  localparam logic [CNT_W-1:0] CNT_MAX = 4'd15;
  localparam logic [ACC_W-1:0] ACC_SAT = 14'd10000;
  localparam logic [ACC_W-1:0] YEAR_MIN = 14'd1900;
  localparam logic [ACC_W-1:0] YEAR_MAX = 14'd9999;

  localparam logic [7:0] CHAR_SLASH = 8'h2F;
  localparam logic [7:0] CHAR_ZERO  = 8'h30;
  localparam logic [7:0] CHAR_NINE  = 8'h39;

  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_FORMAT  = 2'd1;
  localparam logic [1:0] ST_CONTENT = 2'd2;
  localparam logic [1:0] ST_SEQ     = 2'd3;

  // Finished per-string state, handed from the parse stage to the judge stage.
  typedef struct packed {
    logic [CNT_W-1:0] count;
    logic [1:0]       slashes;
    logic             bad;
    logic [ACC_W-1:0] year;
    logic [ACC_W-1:0] month;
    logic [ACC_W-1:0] day;
    logic [15:0]      year_digits;  // last four year digits, ones in the low nibble
  } judge_t;

  function automatic logic [ACC_W-1:0] push_digit(input logic [ACC_W-1:0] acc,
                                                  input logic [3:0] dv);
    logic [ACC_W+2:0] v;
    v = ({3'b000, acc} << 3) + ({3'b000, acc} << 1) + {{(ACC_W-1){1'b0}}, dv};
    return (v >= {3'b000, ACC_SAT}) ? ACC_SAT : v[ACC_W-1:0];
  endfunction

  // Gregorian leap rule from the last four decimal digits of the year.
  // A two-digit number 10a+b is divisible by four exactly when 2a+b is.
  function automatic logic is_leap(input logic [15:0] dig);
    logic [4:0] low_sum;
    logic [4:0] high_sum;
    logic       div4;
    logic       div100;
    logic       div400;
    low_sum  = {dig[7:4], 1'b0} + {1'b0, dig[3:0]};
    high_sum = {dig[15:12], 1'b0} + {1'b0, dig[11:8]};
    div4     = (low_sum[1:0] == 2'b00);
    div100   = (dig[7:0] == 8'h00);
    div400   = div100 && (high_sum[1:0] == 2'b00);
    return (div4 && !div100) || div400;
  endfunction

  function automatic logic [4:0] month_len(input logic leap,
                                           input logic [ACC_W-1:0] month);
    logic [4:0] len;
    unique case (month)
      14'd2:                        len = leap ? 5'd29 : 5'd28;
      14'd4, 14'd6, 14'd9, 14'd11:  len = 5'd30;
      default:                      len = 5'd31;
    endcase
    return len;
  endfunction

endpackage

### rtl/date_string_check_monotonic.sv
// Date string checker: parses year/month/day strings and keeps a monotonic date.
// A final character's result passes through the input register, the judge register
// and the output register before it can leave.
// Throughput: one character per cycle; results never block further characters
// unless both the judge and output registers hold unaccepted results.
// Reset clears all handshake and per-string state and sets the stored date to 1900/1/1.
`include "date_string_check_monotonic_assert.svh"

module date_string_check_monotonic
  import dscm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_in
  input  logic        s_tlast,   // last_char
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata    // [1:0] status, [15:2] current_year,
                                 // [19:16] current_month, [24:20] current_day
);

  // Input register.
  logic       iv;
  logic [7:0] ichar;
  logic       ilast;

  // Per-string parse state.
  logic [CNT_W-1:0] char_count, char_count_next;
  logic [1:0]       slash_count, slash_count_next;
  logic             format_bad, format_bad_next;
  logic [ACC_W-1:0] year_acc, year_acc_next;
  logic [ACC_W-1:0] month_acc, month_acc_next;
  logic [ACC_W-1:0] day_acc, day_acc_next;
  logic [15:0]      year_dig, year_dig_next;

  // Judge stage.
  logic   jv;
  judge_t jd;
  judge_t jd_next;
  logic   [1:0] j_status;

  // Stored date and output register.
  logic [ACC_W-1:0] held_year;
  logic [3:0]       held_month;
  logic [4:0]       held_day;
  logic [1:0]       out_status;
  logic [ACC_W-1:0] out_year;
  logic [3:0]       out_month;
  logic [4:0]       out_day;

  logic out_rdy;
  logic j_rdy;
  logic i_fire;
  logic is_slash;
  logic is_digit;
  logic fmt_err;
  logic range_err;
  logic early;

  // Terms used by the assertions.
  logic        held_in_range;
  logic        out_is_held;
  logic        judge_err;
  logic [22:0] held_date;

  assign out_rdy  = !m_tvalid || m_tready;
  assign j_rdy    = !jv || out_rdy;
  // Only a final character needs room in the judge stage.
  assign i_fire   = iv && (!ilast || j_rdy);
  assign s_tready = !iv || i_fire;

  // Parse one character.
  always_comb begin
    is_slash = (ichar == CHAR_SLASH);
    is_digit = (ichar >= CHAR_ZERO) && (ichar <= CHAR_NINE);

    char_count_next  = (char_count == CNT_MAX) ? char_count : char_count + 4'd1;
    slash_count_next = slash_count;
    format_bad_next  = format_bad;
    year_acc_next    = year_acc;
    month_acc_next   = month_acc;
    day_acc_next     = day_acc;
    year_dig_next    = year_dig;

    if (is_slash) begin
      if (slash_count != 2'd3) slash_count_next = slash_count + 2'd1;
    end else if (is_digit) begin
      unique case (slash_count)
        2'd0: begin
          year_acc_next = push_digit(year_acc, ichar[3:0]);
          year_dig_next = {year_dig[11:0], ichar[3:0]};
        end
        2'd1:    month_acc_next = push_digit(month_acc, ichar[3:0]);
        2'd2:    day_acc_next   = push_digit(day_acc, ichar[3:0]);
        default: ;
      endcase
    end else begin
      format_bad_next = 1'b1;
    end

    jd_next.count       = char_count_next;
    jd_next.slashes     = slash_count_next;
    jd_next.bad         = format_bad_next;
    jd_next.year        = year_acc_next;
    jd_next.month       = month_acc_next;
    jd_next.day         = day_acc_next;
    jd_next.year_digits = year_dig_next;
  end

  // Judge a finished string against the stored date.
  always_comb begin
    fmt_err   = (jd.count != CNT_W'(STRING_LENGTH)) || jd.bad || (jd.slashes != 2'd2);
    range_err = (jd.year < YEAR_MIN) || (jd.year > YEAR_MAX) ||
                (jd.month < 14'd1) || (jd.month > 14'd12) ||
                (jd.day < 14'd1) || (jd.day > 14'd31);
    // Field widths are fixed, so one concatenated compare orders the dates.
    early     = {jd.year, jd.month[3:0], jd.day[4:0]} <
                {held_year, held_month, held_day};
    priority if (fmt_err) begin
      j_status = ST_FORMAT;
    end else if (range_err) begin
      j_status = ST_CONTENT;
    end else if (jd.day > {9'd0, month_len(is_leap(jd.year_digits), jd.month)}) begin
      j_status = ST_CONTENT;
    end else if (early) begin
      j_status = ST_SEQ;
    end else begin
      j_status = ST_OK;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      iv          <= 1'b0;
      char_count  <= '0;
      slash_count <= '0;
      format_bad  <= 1'b0;
      year_acc    <= '0;
      month_acc   <= '0;
      day_acc     <= '0;
      year_dig    <= '0;
      jv          <= 1'b0;
      m_tvalid    <= 1'b0;
      held_year   <= YEAR_MIN;
      held_month  <= 4'd1;
      held_day    <= 5'd1;
    end else begin
      if (s_tready) iv <= s_tvalid;

      if (i_fire) begin
        if (ilast) begin
          char_count  <= '0;
          slash_count <= '0;
          format_bad  <= 1'b0;
          year_acc    <= '0;
          month_acc   <= '0;
          day_acc     <= '0;
          year_dig    <= '0;
        end else begin
          char_count  <= char_count_next;
          slash_count <= slash_count_next;
          format_bad  <= format_bad_next;
          year_acc    <= year_acc_next;
          month_acc   <= month_acc_next;
          day_acc     <= day_acc_next;
          year_dig    <= year_dig_next;
        end
      end

      if (i_fire && ilast) jv <= 1'b1;
      else if (out_rdy)    jv <= 1'b0;

      if (out_rdy) m_tvalid <= jv;

      if (jv && out_rdy && (j_status == ST_OK)) begin
        held_year  <= jd.year;
        held_month <= jd.month[3:0];
        held_day   <= jd.day[4:0];
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      ichar <= s_tdata;
      ilast <= s_tlast;
    end
    if (i_fire && ilast) jd <= jd_next;
    if (jv && out_rdy) begin
      out_status <= j_status;
      if (j_status == ST_OK) begin
        out_year  <= jd.year;
        out_month <= jd.month[3:0];
        out_day   <= jd.day[4:0];
      end else begin
        out_year  <= held_year;
        out_month <= held_month;
        out_day   <= held_day;
      end
    end
  end

  assign m_tdata = {7'd0, out_day, out_month, out_year, out_status};

  assign held_in_range = (held_year >= YEAR_MIN) && (held_year <= YEAR_MAX) &&
                         (held_month >= 4'd1) && (held_month <= 4'd12) &&
                         (held_day >= 5'd1);
  assign out_is_held   = (out_year == held_year) && (out_month == held_month) &&
                         (out_day == held_day);
  assign judge_err     = jv && out_rdy && (j_status != ST_OK);
  assign held_date     = {held_year, held_month, held_day};

  `DSCM_ASSERT_NOW(a_held_valid, 1'b1, held_in_range, "stored date out of range")
  `DSCM_ASSERT_NOW(a_out_matches_held, m_tvalid, out_is_held, "output date differs from stored date")
  `DSCM_ASSERT_NEXT(a_err_keeps_date, judge_err, $stable(held_date), "stored date changed on an error")
  `DSCM_ASSERT_NEXT(a_judge_held, jv && !out_rdy, jv && $stable(jd), "stalled judge entry lost")

endmodule

### bench/date_result_checker.sv
// Checker that models the date string parse and the held date, and compares each result.
`timescale 1ns / 100ps

module date_result_checker
  import dscm_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,     // [7:0] char_in
  input  logic        s_tlast,     // last_char
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,     // [1:0] status, [15:2] current_year,
                                   // [19:16] current_month, [24:20] current_day
  output int          pending,
  output int          fail_count
);

  typedef struct packed {
    logic [1:0]       status;
    logic [ACC_W-1:0] year;
    logic [3:0]       month;
    logic [4:0]       day;
  } date_result_t;

  // Per-string parse state.
  logic [CNT_W-1:0] seen_len;
  logic [1:0]       slash_seen;
  logic             junk_seen;
  logic [ACC_W-1:0] acc_year;
  logic [ACC_W-1:0] acc_month;
  logic [ACC_W-1:0] acc_day;

  // Date that survives from string to string.
  logic [ACC_W-1:0] cur_year;
  logic [3:0]       cur_month;
  logic [4:0]       cur_day;

  date_result_t dates_due[$];
  int           mismatches;

  function automatic logic [ACC_W-1:0] append_digit(input logic [ACC_W-1:0] acc,
                                                    input logic [7:0] ch);
    int v;
    v = int'(acc) * 10 + int'(ch) - int'(CHAR_ZERO);
    return (v >= int'(ACC_SAT)) ? ACC_SAT : v[ACC_W-1:0];
  endfunction

  function automatic int days_in(input int y, input int m);
    logic leap;
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  task automatic clear_string();
    seen_len   = '0;
    slash_seen = '0;
    junk_seen  = 1'b0;
    acc_year   = '0;
    acc_month  = '0;
    acc_day    = '0;
  endtask

  task automatic judge_string(output logic [1:0] st);
    int y;
    int m;
    int d;
    y = int'(acc_year);
    m = int'(acc_month);
    d = int'(acc_day);
    if (seen_len != STRING_LENGTH || junk_seen || slash_seen != 2'd2) begin
      st = ST_FORMAT;
    end else if (y < int'(YEAR_MIN) || y > int'(YEAR_MAX) || m < 1 || m > 12 ||
                 d < 1 || d > 31 || d > days_in(y, m)) begin
      st = ST_CONTENT;
    end else if (y < int'(cur_year) ||
                 (y == int'(cur_year) && (m < int'(cur_month) ||
                                          (m == int'(cur_month) && d < int'(cur_day))))) begin
      st = ST_SEQ;
    end else begin
      st        = ST_OK;
      cur_year  = ACC_W'(y);
      cur_month = 4'(m);
      cur_day   = 5'(d);
    end
  endtask

  task automatic take_char(input logic [7:0] ch, input logic lst);
    date_result_t r;
    if (seen_len != CNT_MAX) seen_len++;
    if (ch == CHAR_SLASH) begin
      if (slash_seen != 2'd3) slash_seen++;
    end else if (ch >= CHAR_ZERO && ch <= CHAR_NINE) begin
      // Digits after a third slash belong to no field.
      case (slash_seen)
        2'd0:    acc_year  = append_digit(acc_year, ch);
        2'd1:    acc_month = append_digit(acc_month, ch);
        2'd2:    acc_day   = append_digit(acc_day, ch);
        default: ;
      endcase
    end else begin
      junk_seen = 1'b1;
    end
    if (lst) begin
      judge_string(r.status);
      r.year  = cur_year;
      r.month = cur_month;
      r.day   = cur_day;
      dates_due.push_back(r);
      clear_string();
    end
  endtask

  task automatic check_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endtask

  task automatic compare_result(input logic [31:0] word);
    date_result_t want;
    if (dates_due.size() == 0) begin
      $error("result transfer with nothing expected: tdata %h", word);
      mismatches++;
    end else begin
      want = dates_due.pop_front();
      check_field("status", int'(want.status), int'(word[1:0]));
      check_field("current_year", int'(want.year), int'(word[15:2]));
      check_field("current_month", int'(want.month), int'(word[19:16]));
      check_field("current_day", int'(want.day), int'(word[24:20]));
      check_field("padding", 0, int'(word[31:25]));
    end
  endtask

  // Results are taken before characters so a stray result is never matched
  // against an expectation created at the same edge.
  always @(posedge clk) begin
    if (rst) begin
      clear_string();
      cur_year  = YEAR_MIN;
      cur_month = 4'd1;
      cur_day   = 5'd1;
      dates_due.delete();
      mismatches = 0;
    end else begin
      if (m_tvalid && m_tready) compare_result(m_tdata);
      if (s_tvalid && s_tready) take_char(s_tdata, s_tlast);
    end
    pending    <= dates_due.size();
    fail_count <= mismatches;
  end

endmodule

### bench/tb_date_string_check_monotonic.sv
// Testbench top for the date string checker: reset, stimulus, idling phases and verdict.
`timescale 1ns / 100ps

module tb_date_string_check_monotonic;
  import dscm_pkg::*;

  logic        clk      = 1'b0;
  logic        rst      = 1'b1;
  logic        s_tvalid = 1'b0;
  logic        s_tready;
  logic [7:0]  s_tdata  = 8'h00;
  logic        s_tlast  = 1'b0;
  logic        m_tvalid;
  logic        m_tready = 1'b0;
  logic [31:0] m_tdata;

  int pending;
  int fail_count;
  int tx_idle_pct  = 0;
  int rx_stall_pct = 0;
  int chars_sent   = 0;
  int rand_base;

  // Date the generator walks forward so that most well-formed strings land near
  // the held date instead of far behind it.
  int gen_year;
  int gen_month;
  int gen_day;

  logic [7:0] line_q[$];

  always #5 clk = ~clk;

  date_string_check_monotonic DUT (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  date_result_checker date_checker (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .pending    (pending),
    .fail_count (fail_count)
  );

  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  function automatic logic [7:0] random_char();
    int r;
    r = $urandom_range(0, 99);
    if (r < 40) return CHAR_ZERO + 8'($urandom_range(0, 9));
    if (r < 55) return CHAR_SLASH;
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic put_text(input string s);
    for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
  endtask

  task automatic put_num(input int value, input int ndigits);
    int div;
    div = 1;
    repeat (ndigits - 1) div = div * 10;
    repeat (ndigits) begin
      line_q.push_back(CHAR_ZERO + 8'((value / div) % 10));
      div = div / 10;
    end
  endtask

  // Sends the buffered string, one transfer per character, last on the final one.
  task automatic send_line();
    for (int i = 0; i < line_q.size(); i++) begin
      while ($urandom_range(0, 99) < tx_idle_pct) begin
        s_tvalid <= 1'b0;
        @(posedge clk);
      end
      s_tvalid <= 1'b1;
      s_tdata  <= line_q[i];
      s_tlast  <= (i == line_q.size() - 1);
      do @(posedge clk); while (!s_tready);
      chars_sent++;
    end
    line_q.delete();
  endtask

  task automatic send_text(input string s);
    put_text(s);
    send_line();
  endtask

  task automatic drain_results();
    s_tvalid <= 1'b0;
    do @(posedge clk); while (pending != 0);
  endtask

  task automatic build_random_line();
    int pick;
    int y;
    int m;
    int d;
    int nm;
    int nd;
    int pos;
    pick = $urandom_range(0, 99);
    y = gen_year + $urandom_range(0, 2);
    if (y > 9998) y = 9998;   // the last day of the calendar is kept for the end
    m = $urandom_range(1, 12);
    d = ($urandom_range(0, 9) == 0) ? $urandom_range(29, 31) : $urandom_range(1, 28);
    if (pick < 60) begin
      // Within the same year some of these can fall before the held date.
      if (y > gen_year || (y == gen_year && (m > gen_month ||
                                             (m == gen_month && d >= gen_day)))) begin
        gen_year  = y;
        gen_month = m;
        gen_day   = d;
      end
    end else if (pick < 70) begin
      y = gen_year - $urandom_range(0, 5);
      if (y < 1900) y = 1900;
    end else if (pick < 80) begin
      case ($urandom_range(0, 4))
        0:       m = 0;
        1:       m = $urandom_range(13, 99);
        2:       d = 0;
        3:       d = $urandom_range(32, 99);
        default: y = $urandom_range(1000, 1899);
      endcase
    end
    if (pick < 90) begin
      nm = (m < 10) ? $urandom_range(1, 3) : $urandom_range(2, 3);
      nd = (d < 10) ? $urandom_range(1, 3) : $urandom_range(2, 3);
      if (8 - nm - nd < 4) begin
        nm = 2;
        nd = 2;
      end
      put_num(y, 8 - nm - nd);
      line_q.push_back(CHAR_SLASH);
      put_num(m, nm);
      line_q.push_back(CHAR_SLASH);
      put_num(d, nd);
      if (pick >= 80) begin
        // Broken sequence: drop, insert or overwrite one character.
        pos = $urandom_range(0, line_q.size() - 1);
        case ($urandom_range(0, 2))
          0:       line_q.delete(pos);
          1:       line_q.insert(pos, random_char());
          default: line_q[pos] = random_char();
        endcase
      end
    end else begin
      repeat ($urandom_range(1, 18)) line_q.push_back(random_char());
    end
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_text("1900/01/01");   // equal to the reset date
    send_text("1900/02/29");   // century year, not leap
    send_text("2000/02/29");   // divisible by 400, leap
    send_text("2003/02/29");
    send_text("2004/02/29");
    send_text("2004/02/28");   // earlier than the held date
    send_text("2004/04/31");
    send_text("2004/13/01");
    send_text("2004/00/10");
    send_text("2004/06/00");
    send_text("1899/12/31");
    send_text("9999/12/32");
    send_text("123456/1/1");   // year run saturates
    send_text("//12345678");   // empty year run
    send_text("2004/1/1/5");   // digits after a third slash
    put_text("2004/07/0");
    line_q.push_back(8'h00);
    send_line();
    line_q.push_back(8'hFF);
    put_text("004/07/01");
    send_line();
    send_text("2004/07/3:");
    send_text("2004/07/011");
    send_text("2004/07/012004/07/01");   // length counter saturates
    send_text("5");
    send_text("2004/07/31");
    send_text("2004/7/031");

    gen_year  = 2004;
    gen_month = 7;
    gen_day   = 31;
    rand_base = chars_sent;
    for (int ph = 0; ph < 4; ph++) begin
      drain_results();
      case (ph)
        0: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 0;
        end
        1: begin
          tx_idle_pct = 48;
          rx_stall_pct <= 0;
        end
        2: begin
          tx_idle_pct = 0;
          rx_stall_pct <= 48;
        end
        default: begin
          tx_idle_pct = 17;
          rx_stall_pct <= 17;
        end
      endcase
      while (chars_sent < rand_base + (ph + 1) * 125) begin
        build_random_line();
        send_line();
      end
    end

    send_text("9999/12/31");
    send_text("9999/12/31");

    drain_results();
    repeat (10) @(posedge clk);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
